FILE: design/svgfs_pkg.sv
// ----------------------------------------------------------------------------
// svgfs_pkg
// Shared types and constants of the servo grayscale frame serializer.
// ----------------------------------------------------------------------------
package svgfs_pkg;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned ChW        = 5;
  localparam int unsigned GrayW      = 12;
  localparam int unsigned AngleW     = 8;
  localparam int unsigned TickW      = 16;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned ProdW      = AngleW + GrayW;
  localparam int unsigned DivCntW    = $clog2(ProdW);

  typedef enum logic [2:0] {
    K_SET_CH_RAW    = 3'd0,
    K_SET_ALL_RAW   = 3'd1,
    K_SET_CH_ANGLE  = 3'd2,
    K_SET_ALL_ANGLE = 3'd3,
    K_UPDATE        = 3'd4,
    K_TICK          = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MIN_WIDTH  = 2'd0,
    CFG_MAX_WIDTH  = 2'd1,
    CFG_MAX_ANGLE  = 2'd2,
    CFG_RATE_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_FILL,
    ST_REFUSE,
    ST_RD0,
    ST_RD1,
    ST_B0,
    ST_B1,
    ST_B2
  } state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } ang_state_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ChW-1:0]    channel;
    logic [GrayW-1:0]  value;
    logic [AngleW-1:0] angle;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] frame_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic             we;
    logic [ChW-1:0]   waddr;
    logic [GrayW-1:0] wdata;
    logic             re;
    logic [ChW-1:0]   raddr;
  } store_req_t;

endpackage

FILE: design/svgfs_store.sv
// ----------------------------------------------------------------------------
// svgfs_store
// Grayscale word store: synchronous memory, registered read, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module svgfs_store
  import svgfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  output logic [GrayW-1:0] rdata_o
);

  logic [GrayW-1:0]      mem [StoreDepth];
  logic [StoreDepth-1:0] vld_q;
  logic [GrayW-1:0]      rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: design/svgfs_angle.sv
// ----------------------------------------------------------------------------
// svgfs_angle
// Angle to grayscale conversion: clamp, one registered multiply, then a
// restoring divider retiring one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svgfs_angle
  import svgfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AngleW-1:0] angle_i,
  input  logic [GrayW-1:0]  min_width_i,
  input  logic [GrayW-1:0]  max_width_i,
  input  logic [AngleW-1:0] max_angle_i,
  output logic              done_o,
  output logic [GrayW-1:0]  gray_o
);

  ang_state_e         state_q, state_d;
  logic [AngleW-1:0]  ang_q, div_q;
  logic [GrayW-1:0]   span_q, min_q;
  logic               zero_div_q;
  logic [ProdW-1:0]   dq_q, dq_d;
  logic [AngleW-1:0]  rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [AngleW:0]    trial;
  logic [AngleW:0]    diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == A_IDLE && start_i) begin
      ang_q      <= (angle_i > max_angle_i) ? max_angle_i : angle_i;
      span_q     <= (max_width_i >= min_width_i) ? max_width_i - min_width_i : '0;
      div_q      <= max_angle_i;
      min_q      <= min_width_i;
      zero_div_q <= (max_angle_i == '0);
    end
    dq_q  <= dq_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign trial = {rem_q, dq_q[ProdW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          state_d = A_MUL;
        end
      end
      A_MUL: begin
        dq_d    = ProdW'(ang_q) * ProdW'(span_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = A_DIV;
      end
      A_DIV: begin
        if (!diff[AngleW]) begin
          rem_d = diff[AngleW-1:0];
          dq_d  = {dq_q[ProdW-2:0], 1'b1};
        end else begin
          rem_d = trial[AngleW-1:0];
          dq_d  = {dq_q[ProdW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(ProdW - 1)) begin
          state_d = A_FIN;
        end
      end
      A_FIN: begin
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  // quotient never exceeds the span, so its low bits are exact
  assign done_o = (state_q == A_FIN);
  assign gray_o = zero_div_q ? ~min_q : ~min_q - dq_q[GrayW-1:0];

endmodule

FILE: design/servo_grayscale_frame_serializer_core.sv
// ----------------------------------------------------------------------------
// servo_grayscale_frame_serializer_core
// Per-channel 12-bit grayscale store with servo angle conversion, tick
// counting with update rate limit, and packed frame byte emission.
//
//   channel | handshake             | word
//   --------+-----------------------+------------------------------
//   in      | in_valid_i/in_ready_o | in_word_i (kind, channel, ...)
//   out     | out_valid_o/out_ready_i | out_word_o (accepted, byte, last)
//   cfg     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// Raw single-channel writes and ticks are done in the cycle the word is taken;
// angle writes wait for the 20-step bit-serial divider; set-all writes of either
// kind fill all NUM_CHIPS*16 channels, one store write per cycle. A frame emits
// each 3 bytes from two store reads and three output words.
// Reset clears the store through per-entry valid bits, no clearing pass.
// A stalled output holds its word; once its last word is pushed, the next input is taken meanwhile.
// ----------------------------------------------------------------------------
module servo_grayscale_frame_serializer_core
  import svgfs_pkg::*;
#(
  parameter int unsigned NUM_CHIPS = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned NumChannels = NUM_CHIPS * 16;
  localparam int unsigned NumGroups   = NUM_CHIPS * 8;
  localparam int unsigned GrpW        = $clog2(NumGroups);

  state_e            state_q, state_d;
  logic [GrayW-1:0]  min_width_q, max_width_q;
  logic [AngleW-1:0] max_angle_q;
  logic [TickW-1:0]  rate_limit_q, ticks_q, ticks_d;
  logic [GrpW-1:0]   grp_q, grp_d;
  logic [ChW-1:0]    fill_q, fill_d, pend_ch_q, pend_ch_d;
  logic              pend_all_q, pend_all_d;
  logic [GrayW-1:0]  fill_val_q, fill_val_d, w0_q, w0_d;
  logic              out_valid_q;
  out_word_t         out_word_q, push_word;
  logic              push, slot_free;
  store_req_t        store_req;
  logic [GrayW-1:0]  rdata;
  logic              ang_start, ang_done;
  logic [GrayW-1:0]  ang_gray;
  logic [ChW-1:0]    addr0;
  logic              in_fire, ch_ok, pend_ok, grp_last;

  svgfs_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (rdata)
  );

  svgfs_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ang_start),
    .angle_i     (in_word_i.angle),
    .min_width_i (min_width_q),
    .max_width_i (max_width_q),
    .max_angle_i (max_angle_q),
    .done_o      (ang_done),
    .gray_o      (ang_gray)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign ch_ok       = ({1'b0, in_word_i.channel} < (ChW + 1)'(NumChannels));
  assign pend_ok     = ({1'b0, pend_ch_q} < (ChW + 1)'(NumChannels));
  assign addr0       = ChW'(NumChannels - 1) - ChW'({grp_q, 1'b0});
  assign grp_last    = (grp_q == GrpW'(NumGroups - 1));
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ticks_q      <= '0;
      grp_q        <= '0;
      fill_q       <= '0;
      pend_all_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      min_width_q  <= GrayW'(205);
      max_width_q  <= GrayW'(410);
      max_angle_q  <= AngleW'(180);
      rate_limit_q <= TickW'(20);
    end else begin
      state_q    <= state_d;
      ticks_q    <= ticks_d;
      grp_q      <= grp_d;
      fill_q     <= fill_d;
      pend_all_q <= pend_all_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MIN_WIDTH:  min_width_q  <= cfg_data_i[GrayW-1:0];
          CFG_MAX_WIDTH:  max_width_q  <= cfg_data_i[GrayW-1:0];
          CFG_MAX_ANGLE:  max_angle_q  <= cfg_data_i[AngleW-1:0];
          CFG_RATE_LIMIT: rate_limit_q <= cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ch_q  <= pend_ch_d;
    fill_val_q <= fill_val_d;
    w0_q       <= w0_d;
    if (push) begin
      out_word_q <= push_word;
    end
  end

  always_comb begin
    state_d         = state_q;
    ticks_d         = ticks_q;
    grp_d           = grp_q;
    fill_d          = fill_q;
    pend_all_d      = pend_all_q;
    pend_ch_d       = pend_ch_q;
    fill_val_d      = fill_val_q;
    w0_d            = w0_q;
    push            = 1'b0;
    push_word       = '0;
    ang_start       = 1'b0;
    store_req       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pend_ch_d = in_word_i.channel;
          case (in_word_i.kind)
            K_SET_CH_RAW: begin
              store_req.we    = ch_ok;
              store_req.waddr = in_word_i.channel;
              store_req.wdata = in_word_i.value;
            end
            K_SET_ALL_RAW: begin
              fill_val_d = in_word_i.value;
              fill_d     = '0;
              state_d    = ST_FILL;
            end
            K_SET_CH_ANGLE, K_SET_ALL_ANGLE: begin
              ang_start  = 1'b1;
              pend_all_d = (in_word_i.kind == K_SET_ALL_ANGLE);
              state_d    = ST_ANGLE;
            end
            K_UPDATE: begin
              grp_d   = '0;
              state_d = (ticks_q < rate_limit_q) ? ST_REFUSE : ST_RD0;
            end
            K_TICK: begin
              if (ticks_q != '1) begin
                ticks_d = ticks_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ANGLE: begin
        if (ang_done) begin
          if (pend_all_q) begin
            fill_val_d = ang_gray;
            fill_d     = '0;
            state_d    = ST_FILL;
          end else begin
            store_req.we    = pend_ok;
            store_req.waddr = pend_ch_q;
            store_req.wdata = ang_gray;
            state_d         = ST_IDLE;
          end
        end
      end
      ST_FILL: begin
        store_req.we    = 1'b1;
        store_req.waddr = fill_q;
        store_req.wdata = fill_val_q;
        fill_d          = fill_q + 1'b1;
        if (fill_q == ChW'(NumChannels - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_REFUSE: begin
        if (slot_free) begin
          push           = 1'b1;
          push_word.last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RD0: begin
        store_req.re    = 1'b1;
        store_req.raddr = addr0;
        state_d         = ST_RD1;
      end
      ST_RD1: begin
        store_req.re    = 1'b1;
        store_req.raddr = addr0 - 1'b1;
        w0_d            = rdata;
        state_d         = ST_B0;
      end
      ST_B0: begin
        if (slot_free) begin
          push                 = 1'b1;
          push_word.accepted   = 1'b1;
          push_word.frame_byte = w0_q[11:4];
          state_d              = ST_B1;
        end
      end
      ST_B1: begin
        if (slot_free) begin
          push                 = 1'b1;
          push_word.accepted   = 1'b1;
          push_word.frame_byte = {w0_q[3:0], rdata[11:8]};
          state_d              = ST_B2;
        end
      end
      ST_B2: begin
        if (slot_free) begin
          push                 = 1'b1;
          push_word.accepted   = 1'b1;
          push_word.frame_byte = rdata[7:0];
          push_word.last       = grp_last;
          if (grp_last) begin
            ticks_d = '0;
            state_d = ST_IDLE;
          end else begin
            grp_d   = grp_q + 1'b1;
            state_d = ST_RD0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store is never written while a frame is being read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD0 || state_q == ST_RD1 || state_q == ST_B0 ||
     state_q == ST_B1 || state_q == ST_B2) |-> !store_req.we)
    else $error("store write during frame readout");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.accepted |->
      out_word_o.last && (out_word_o.frame_byte == '0))
    else $error("malformed refusal word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ang_done |-> (state_q == ST_ANGLE))
    else $error("angle result outside angle wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> slot_free)
    else $error("output word overwritten");

endmodule
